@@ design/i2cmts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transaction sequencer - shared definitions
// Phase, action and status codes, the item and result structs, and the
// bundle of results that one input word produces.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  // Input operations (in_tuser)
  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_WBYTE  = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;
  localparam logic [1:0] OP_TICK   = 2'd3;

  // Transaction phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_WAIT_BUS = 4'd1;
  localparam logic [3:0] PH_W_START  = 4'd2;
  localparam logic [3:0] PH_W_ADDR   = 4'd3;
  localparam logic [3:0] PH_W_NEED   = 4'd4;
  localparam logic [3:0] PH_W_DATA   = 4'd5;
  localparam logic [3:0] PH_R_START  = 4'd6;
  localparam logic [3:0] PH_R_ADDR   = 4'd7;
  localparam logic [3:0] PH_R_DATA   = 4'd8;

  // Result actions (out_tuser)
  localparam logic [2:0] ACT_START   = 3'd0;
  localparam logic [2:0] ACT_SEND    = 3'd1;
  localparam logic [2:0] ACT_REQ     = 3'd2;
  localparam logic [2:0] ACT_ACK_ON  = 3'd3;
  localparam logic [2:0] ACT_ACK_OFF = 3'd4;
  localparam logic [2:0] ACT_READ    = 3'd5;
  localparam logic [2:0] ACT_CLR_AF  = 3'd6;
  localparam logic [2:0] ACT_STOP    = 3'd7;

  // Stop status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUSY_TO = 3'd1;
  localparam logic [2:0] ST_BUS_TO  = 3'd2;
  localparam logic [2:0] ST_ANACK   = 3'd3;
  localparam logic [2:0] ST_DNACK   = 3'd4;

  localparam logic [7:0]  ADDR_WRITE_MASK = 8'hFE;
  localparam logic [15:0] TIMEOUT_RESET   = 16'd50;
  localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

  // At most two result words follow from one input word
  localparam int MAX_RES = 2;
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int SUB_W   = $clog2(MAX_RES);

  typedef struct packed {
    logic [7:0]  target_address;
    logic [15:0] write_count;
    logic [15:0] read_count;
    logic [7:0]  data_byte;
    logic        bus_busy;
    logic        start_sent;
    logic        address_sent;
    logic        byte_transferred;
    logic        ack_failed;
    logic        rx_ready;
  } item_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [15:0] elapsed_ms;
    logic [15:0] writes_left;
    logic [15:0] reads_left;
    logic [7:0]  address_byte;
  } seq_state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_out;
    logic [2:0] status;
  } result_t;

  typedef struct packed {
    logic [CNT_W-1:0]          cnt;
    result_t [MAX_RES-1:0]     res;
  } bundle_t;

  function automatic result_t mk_res(logic [2:0] act, logic [7:0] b, logic [2:0] st);
    result_t r;
    r.action   = act;
    r.byte_out = b;
    r.status   = st;
    return r;
  endfunction

endpackage

@@ design/i2cmts_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transaction sequencer - phase step
// Combinational next state and result bundle for one accepted word.
// ----------------------------------------------------------------------------
module i2cmts_step
  import i2cmts_pkg::*;
(
  input  seq_state_t st,
  input  logic [15:0] timeout_ms,
  input  logic [1:0]  op,
  input  item_t       item,
  output seq_state_t  st_nxt,
  output bundle_t     bnd
);

  logic [15:0] elapsed_inc;
  logic [15:0] reads_dec;

  // Saturating tick count and remaining read count after one byte
  assign elapsed_inc = (st.elapsed_ms < ELAPSED_MAX) ? st.elapsed_ms + 16'd1 : st.elapsed_ms;
  assign reads_dec   = st.reads_left - 16'd1;

  always_comb begin
    st_nxt = st;
    bnd    = '0;
    case (op)
      OP_BEGIN: begin
        // Latch a new transaction only when idle
        if (st.phase == PH_IDLE) begin
          st_nxt.address_byte = item.target_address;
          st_nxt.writes_left  = item.write_count;
          st_nxt.reads_left   = item.read_count;
          st_nxt.elapsed_ms   = '0;
          st_nxt.phase        = PH_WAIT_BUS;
        end
      end
      OP_TICK: begin
        // Advance the transaction budget, stop on expiry
        if (st.phase != PH_IDLE) begin
          st_nxt.elapsed_ms = elapsed_inc;
          if (elapsed_inc >= timeout_ms) begin
            bnd.cnt    = CNT_W'(1);
            bnd.res[0] = mk_res(ACT_STOP, 8'd0,
                                (st.phase == PH_WAIT_BUS) ? ST_BUSY_TO : ST_BUS_TO);
            st_nxt.phase = PH_IDLE;
          end
        end
      end
      OP_WBYTE: begin
        // Send the supplied write byte only when one was requested
        if (st.phase == PH_W_NEED) begin
          bnd.cnt            = CNT_W'(1);
          bnd.res[0]         = mk_res(ACT_SEND, item.data_byte, ST_OK);
          st_nxt.writes_left = st.writes_left - 16'd1;
          st_nxt.phase       = PH_W_DATA;
        end
      end
      default: begin
        // Bus status sample
        case (st.phase)
          PH_WAIT_BUS: begin
            if (!item.bus_busy) begin
              bnd.cnt = CNT_W'(1);
              if (st.writes_left != 16'd0) begin
                bnd.res[0]   = mk_res(ACT_START, 8'd0, ST_OK);
                st_nxt.phase = PH_W_START;
              end else if (st.reads_left != 16'd0) begin
                bnd.res[0]   = mk_res(ACT_START, 8'd0, ST_OK);
                st_nxt.phase = PH_R_START;
              end else begin
                bnd.res[0]   = mk_res(ACT_STOP, 8'd0, ST_OK);
                st_nxt.phase = PH_IDLE;
              end
            end
          end
          PH_W_START: begin
            if (item.start_sent) begin
              bnd.cnt      = CNT_W'(1);
              bnd.res[0]   = mk_res(ACT_SEND, st.address_byte & ADDR_WRITE_MASK, ST_OK);
              st_nxt.phase = PH_W_ADDR;
            end
          end
          PH_W_ADDR, PH_R_ADDR: begin
            if (item.ack_failed) begin
              bnd.cnt      = CNT_W'(2);
              bnd.res[0]   = mk_res(ACT_CLR_AF, 8'd0, ST_OK);
              bnd.res[1]   = mk_res(ACT_STOP, 8'd0, ST_ANACK);
              st_nxt.phase = PH_IDLE;
            end else if (item.address_sent) begin
              bnd.cnt = CNT_W'(1);
              if (st.phase == PH_W_ADDR) begin
                bnd.res[0]   = mk_res(ACT_REQ, 8'd0, ST_OK);
                st_nxt.phase = PH_W_NEED;
              end else begin
                bnd.res[0]   = mk_res((st.reads_left > 16'd1) ? ACT_ACK_ON : ACT_ACK_OFF,
                                      8'd0, ST_OK);
                st_nxt.phase = PH_R_DATA;
              end
            end
          end
          PH_W_DATA: begin
            if (item.ack_failed) begin
              bnd.cnt      = CNT_W'(2);
              bnd.res[0]   = mk_res(ACT_CLR_AF, 8'd0, ST_OK);
              bnd.res[1]   = mk_res(ACT_STOP, 8'd0, ST_DNACK);
              st_nxt.phase = PH_IDLE;
            end else if (item.byte_transferred) begin
              bnd.cnt = CNT_W'(1);
              if (st.writes_left != 16'd0) begin
                bnd.res[0]   = mk_res(ACT_REQ, 8'd0, ST_OK);
                st_nxt.phase = PH_W_NEED;
              end else if (st.reads_left != 16'd0) begin
                bnd.res[0]   = mk_res(ACT_START, 8'd0, ST_OK);
                st_nxt.phase = PH_R_START;
              end else begin
                bnd.res[0]   = mk_res(ACT_STOP, 8'd0, ST_OK);
                st_nxt.phase = PH_IDLE;
              end
            end
          end
          PH_R_START: begin
            if (item.start_sent) begin
              bnd.cnt      = CNT_W'(1);
              bnd.res[0]   = mk_res(ACT_SEND, st.address_byte | 8'd1, ST_OK);
              st_nxt.phase = PH_R_ADDR;
            end
          end
          PH_R_DATA: begin
            if (item.ack_failed) begin
              bnd.cnt      = CNT_W'(2);
              bnd.res[0]   = mk_res(ACT_CLR_AF, 8'd0, ST_OK);
              bnd.res[1]   = mk_res(ACT_STOP, 8'd0, ST_DNACK);
              st_nxt.phase = PH_IDLE;
            end else if (item.rx_ready) begin
              st_nxt.reads_left = reads_dec;
              if (reads_dec == 16'd1) begin
                // Drop acknowledge ahead of the final byte
                bnd.cnt    = CNT_W'(2);
                bnd.res[0] = mk_res(ACT_ACK_OFF, 8'd0, ST_OK);
                bnd.res[1] = mk_res(ACT_READ, item.data_byte, ST_OK);
              end else if (reads_dec == 16'd0) begin
                bnd.cnt      = CNT_W'(2);
                bnd.res[0]   = mk_res(ACT_READ, item.data_byte, ST_OK);
                bnd.res[1]   = mk_res(ACT_STOP, 8'd0, ST_OK);
                st_nxt.phase = PH_IDLE;
              end else begin
                bnd.cnt    = CNT_W'(1);
                bnd.res[0] = mk_res(ACT_READ, item.data_byte, ST_OK);
              end
            end
          end
          default: begin
          end
        endcase
      end
    endcase
  end

endmodule

@@ design/i2cmts_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transaction sequencer - result queue
// Holds result bundles and hands them out one word per handshake.
// ----------------------------------------------------------------------------
module i2cmts_queue
  import i2cmts_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  bundle_t push_bnd,
  output logic    full,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res,
  output logic    out_last
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);

  bundle_t            slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [SUB_W-1:0]   sub_r, sub_nxt;
  bundle_t            head;
  logic               pop;

  // Present the current word of the head bundle
  assign head      = slot_r[rd_ptr_r];
  assign full      = (occ_r == OCC_W'(DEPTH));
  assign out_valid = (occ_r != '0);
  assign out_res   = head.res[sub_r];
  assign out_last  = ((CNT_W'(sub_r) + CNT_W'(1)) == head.cnt);
  assign pop       = out_valid && out_ready && out_last;

  // Advance pointers, occupancy and word index
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    sub_nxt    = sub_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (out_valid && out_ready) begin
      if (out_last) begin
        sub_nxt    = '0;
        rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end else begin
        sub_nxt = sub_r + SUB_W'(1);
      end
    end
    occ_nxt = occ_r + OCC_W'(push) - OCC_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      occ_r    <= '0;
      sub_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      occ_r    <= occ_nxt;
      sub_r    <= sub_nxt;
    end
  end

  // Store the incoming bundle
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_bnd;
    end
  end

endmodule

@@ design/i2c_master_transaction_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transaction sequencer - top level
// Steps one write-then-read I2C transaction per begin word and emits the
// controller actions (start, send, ack control, read, stop with status).
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : event words - begin, write byte supplied, bus status sample,
//           millisecond tick. Operation in in_tuser, fields in in_tdata.
//   out_* : action words, action code in out_tuser, out_tlast on the final
//           word caused by one input word.
//   cfg_* : cfg_wen writes the millisecond timeout budget (reset 50); write
//           only while no transaction words are pending.
// Queueing: the action words of an accepted event are stored in the result
//   queue and are presented after any words queued before them.
// Throughput: one input word per cycle while in_tready is high. An event
//   yields zero, one or two action words and the output side drains one
//   word per cycle while out_tready is high. The phase step itself is
//   combinational logic between the state registers.
// Stall: while out_tready is low the current word holds; up to QUEUE_DEPTH
//   event bundles are buffered, after which in_tready drops.
// Reset: rst_n (synchronous) returns to idle, empties the queue and restores
//   the timeout budget.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer
  import i2cmts_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: target_address[7:0], write_count[23:8], read_count[39:24],
  //   data_byte[47:40], bus_busy[48], start_sent[49], address_sent[50],
  //   byte_transferred[51], ack_failed[52], rx_ready[53], zero pad[55:54]
  input  logic [55:0] in_tdata,
  // in_tuser: operation[1:0]
  input  logic [1:0]  in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: byte_out[7:0], status[10:8], zero pad[15:11]
  output logic [15:0] out_tdata,
  // out_tuser: action[2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata
);

  seq_state_t  st_r, st_nxt;
  logic [15:0] timeout_r;
  item_t       item;
  bundle_t     bnd;
  result_t     res;
  logic        q_full;
  logic        accept;

  // Unpack the event word
  assign item.target_address   = in_tdata[7:0];
  assign item.write_count      = in_tdata[23:8];
  assign item.read_count       = in_tdata[39:24];
  assign item.data_byte        = in_tdata[47:40];
  assign item.bus_busy         = in_tdata[48];
  assign item.start_sent       = in_tdata[49];
  assign item.address_sent     = in_tdata[50];
  assign item.byte_transferred = in_tdata[51];
  assign item.ack_failed       = in_tdata[52];
  assign item.rx_ready         = in_tdata[53];

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  i2cmts_step u_step (
    .st         (st_r),
    .timeout_ms (timeout_r),
    .op         (in_tuser),
    .item       (item),
    .st_nxt     (st_nxt),
    .bnd        (bnd)
  );

  // Hold transaction state, update on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // Timeout budget register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wen) begin
      timeout_r <= cfg_wdata;
    end
  end

  i2cmts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && (bnd.cnt != '0)),
    .push_bnd  (bnd),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tuser = res.action;
  assign out_tdata = {5'd0, res.status, res.byte_out};

endmodule

@@ design/i2cmts_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master transaction sequencer - port checker
// Concurrent checks on the action channel, bound to the top level.
// ----------------------------------------------------------------------------
module i2cmts_checker
  import i2cmts_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast,
  input logic        out_tvalid,
  input logic        out_tready
);

  // Hold a stalled word
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled action word changed");

  // A stop always closes its event
  a_stop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ACT_STOP) |-> out_tlast)
    else $error("stop without last");

  // Only send and read carry a byte
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ACT_SEND) && (out_tuser != ACT_READ) |->
    (out_tdata[7:0] == 8'd0))
    else $error("byte on non-data action");

  // Status only on stop, never beyond data nack
  a_status_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[10:8] != ST_OK) |->
    (out_tuser == ACT_STOP) && (out_tdata[10:8] <= ST_DNACK))
    else $error("bad status");

endmodule

bind i2c_master_transaction_sequencer i2cmts_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
